// ===== rtl/core/gfmi_pkg.sv =====
// Shared widths, codes and control types of the GF(2^n) multiply / inverse unit.
package gfmi_pkg;

   localparam int OPERAND_W         = 63;
   localparam int CFG_DEG_W         = 6;
   localparam int MODULUS_W         = 64;
   localparam int WORD_BITS_DEFAULT = 64;
   localparam int CSR_IDX_W         = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_DEGREE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_POLY = 1'b1;

   localparam logic [CFG_DEG_W-1:0] FIELD_DEGREE_RESET = 6'd8;
   localparam logic [CFG_DEG_W-1:0] MIN_DEGREE         = 6'd2;
   localparam logic [MODULUS_W-1:0] MODULUS_RESET      = 64'd283;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_INV = 1'b1;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_BAD_MODULUS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MRED,
      ST_MPROD,
      ST_INV,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_MRED,
      DP_MPROD,
      DP_DIV,
      DP_NORM,
      DP_SWAP
   } dp_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_BAD,
      RES_PROD,
      RES_INV
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        init;
      dp_op_type   op;
      logic        out_load;
      res_sel_type res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic op_inv;
      logic a_zero;
      logic b_zero;
      logic mod_bad;
      logic cnt_last;
      logic div_go;
      logic x_zero;
      logic x_top;
   } dp_status_type;

endpackage

// ===== rtl/core/gfmi_intf.sv =====
// Channel interfaces: request, response and register write port.
interface gfmi_req_if;
   import gfmi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [OPERAND_W-1:0] operand_a;
   logic [OPERAND_W-1:0] operand_b;

   modport source (output valid, output op, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

interface gfmi_rsp_if;
   import gfmi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OPERAND_W-1:0] product_or_inverse;
   logic                 status;

   modport source (output valid, output product_or_inverse, output status, input ready);
   modport sink   (input valid, input product_or_inverse, input status, output ready);
endinterface

interface gfmi_csr_if;
   import gfmi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [MODULUS_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/gf2n_mul_inv_unit.sv =====
// Top level of the GF(2^n) multiply / inverse unit: register port, sequencer and datapath.
//
// One request at a time. Multiply reduces operand_a by Horner steps and then runs
// Horner over operand_b, one bit per cycle each. Inverse runs extended Euclid on the
// left-aligned remainders, one quotient or alignment bit per cycle, with a swap of the
// remainders between divisions. A zero operand_a, or for multiply a zero operand_b,
// and a modulus whose degree is not n skip the arithmetic and answer directly. The
// response register lets the next request be accepted while a response still waits.
module gf2n_mul_inv_unit #(
   parameter int WORD_BITS = gfmi_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   gfmi_req_if.sink    req,
   gfmi_rsp_if.source  rsp,
   gfmi_csr_if.sink    csr
);
   import gfmi_pkg::*;

   logic [CFG_DEG_W-1:0] field_degree_ff;
   logic [MODULUS_W-1:0] modulus_poly_ff;
   dp_cmd_type           cmd;
   dp_status_type        status;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_degree_ff <= FIELD_DEGREE_RESET;
         modulus_poly_ff <= MODULUS_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_FIELD_DEGREE: field_degree_ff <= csr.data[CFG_DEG_W-1:0];
            CSR_MODULUS_POLY: modulus_poly_ff <= csr.data;
            default:          field_degree_ff <= field_degree_ff;
         endcase
      end
   end

   gfmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gfmi_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .op                 (req.op),
      .operand_a          (req.operand_a),
      .operand_b          (req.operand_b),
      .field_degree       (field_degree_ff),
      .modulus_poly       (modulus_poly_ff),
      .product_or_inverse (rsp.product_or_inverse),
      .result_status      (rsp.status)
   );

endmodule

// ===== rtl/core/gfmi_ctrl.sv =====
// Sequencer: walks a request through check, multiply or Euclid steps, and response.
module gfmi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  gfmi_pkg::dp_status_type status,
   output gfmi_pkg::dp_cmd_type    cmd
);
   import gfmi_pkg::*;

   ctrl_state_type state_ff, state_in;
   res_sel_type    res_sel_ff, res_sel_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_ok;
   logic           trivial;

   // response slot free, or being drained this cycle
   assign out_ok  = !rsp_valid_ff || rsp_ready;
   assign trivial = status.op_inv ? status.a_zero : (status.a_zero || status.b_zero);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_sel_ff   <= RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_sel_ff   <= res_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      res_sel_in = res_sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (trivial) begin
               state_in   = ST_DONE;
               res_sel_in = RES_ZERO;
            end else if (status.mod_bad) begin
               state_in   = ST_DONE;
               res_sel_in = RES_BAD;
            end else if (status.op_inv) begin
               state_in = ST_INV;
            end else begin
               state_in = ST_MRED;
            end
         end
         ST_MRED: begin
            if (status.cnt_last) state_in = ST_MPROD;
         end
         ST_MPROD: begin
            if (status.cnt_last) begin
               state_in   = ST_DONE;
               res_sel_in = RES_PROD;
            end
         end
         ST_INV: begin
            if (!status.div_go && status.x_zero) begin
               state_in   = ST_DONE;
               res_sel_in = RES_INV;
            end
         end
         ST_DONE: begin
            if (out_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.op       = DP_NOP;
      cmd.res_sel  = res_sel_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            cmd.init = 1'b1;
         end
         ST_MRED: begin
            cmd.op = DP_MRED;
         end
         ST_MPROD: begin
            cmd.op = DP_MPROD;
         end
         ST_INV: begin
            if (status.div_go) cmd.op = DP_DIV;
            else if (status.x_zero) cmd.op = DP_NOP;
            else if (status.x_top) cmd.op = DP_SWAP;
            else cmd.op = DP_NORM;
         end
         ST_DONE: begin
            if (out_ok) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/gfmi_dpath.sv =====
// Datapath: operand, remainder and coefficient registers with one multiply-by-x step.
module gfmi_dpath #(
   parameter int WORD_BITS = gfmi_pkg::WORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  gfmi_pkg::dp_cmd_type              cmd,
   output gfmi_pkg::dp_status_type           status,
   input  logic                             op,
   input  logic [gfmi_pkg::OPERAND_W-1:0]   operand_a,
   input  logic [gfmi_pkg::OPERAND_W-1:0]   operand_b,
   input  logic [gfmi_pkg::CFG_DEG_W-1:0]   field_degree,
   input  logic [gfmi_pkg::MODULUS_W-1:0]   modulus_poly,
   output logic [gfmi_pkg::OPERAND_W-1:0]   product_or_inverse,
   output logic                             result_status
);
   import gfmi_pkg::*;

   localparam int LOG_W = $clog2(WORD_BITS);
   localparam int DEG_W = LOG_W + 1;
   localparam logic signed [DEG_W-1:0] CX_TOP = DEG_W'(WORD_BITS - 1);
   localparam logic signed [DEG_W-1:0] CX_ONE = DEG_W'(1);
   localparam logic [LOG_W-1:0]        CNT_LAST = LOG_W'(WORD_BITS - 1);

   logic                          op_ff, op_in;
   logic [CFG_DEG_W-1:0]          n_ff, n_in;
   logic [WORD_BITS-1:0]          m_ff, m_in;
   logic [WORD_BITS-1:0]          top_ff, top_in;
   logic [WORD_BITS-1:0]          x_ff, x_in;
   logic [WORD_BITS-1:0]          y_ff, y_in;
   logic [WORD_BITS-1:0]          sx_ff, sx_in;
   logic [WORD_BITS-1:0]          sy_ff, sy_in;
   logic [WORD_BITS-1:0]          h_ff, h_in;
   logic signed [DEG_W-1:0]       cx_ff, cx_in;
   logic signed [DEG_W-1:0]       cy_ff, cy_in;
   logic [LOG_W-1:0]              cnt_ff, cnt_in;
   logic [OPERAND_W-1:0]          result_ff, result_in;
   logic                          rstat_ff, rstat_in;

   logic [CFG_DEG_W-1:0]          n_eff;
   logic [LOG_W-1:0]              align_sh;
   logic [WORD_BITS-1:0]          hx;
   logic                          cnt_last;

   // v * x mod m for v below 2^n; mask selects bit n-1
   function automatic logic [WORD_BITS-1:0] times_x(
      input logic [WORD_BITS-1:0] v,
      input logic [WORD_BITS-1:0] m,
      input logic [WORD_BITS-1:0] mask
   );
      return (v << 1) ^ ((|(v & mask)) ? m : '0);
   endfunction

   assign n_eff    = (field_degree < MIN_DEGREE) ? MIN_DEGREE : field_degree;
   // left-align the modulus so its x^n term sits in the top bit
   assign align_sh = CNT_LAST - LOG_W'(n_ff);
   assign hx       = times_x(h_ff, m_ff, top_ff);
   assign cnt_last = (cnt_ff == CNT_LAST);

   assign status.op_inv   = (op_ff == OP_INV);
   assign status.a_zero   = (x_ff == '0);
   assign status.b_zero   = (y_ff == '0);
   assign status.mod_bad  = ((m_ff >> n_ff) != WORD_BITS'(1));
   assign status.cnt_last = cnt_last;
   assign status.div_go   = (cx_ff >= cy_ff);
   assign status.x_zero   = (x_ff == '0);
   assign status.x_top    = x_ff[WORD_BITS-1];

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      n_ff      <= n_in;
      m_ff      <= m_in;
      top_ff    <= top_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      h_ff      <= h_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
      rstat_ff  <= rstat_in;
   end

   always_comb begin
      op_in     = op_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      top_in    = top_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      h_in      = h_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      rstat_in  = rstat_ff;

      if (cmd.load) begin
         op_in  = op;
         n_in   = n_eff;
         m_in   = WORD_BITS'(modulus_poly);
         top_in = WORD_BITS'(1) << (n_eff - 6'd1);
         x_in   = WORD_BITS'(operand_a);
         y_in   = WORD_BITS'(operand_b);
      end

      if (cmd.init) begin
         h_in   = '0;
         cnt_in = '0;
         if (op_ff == OP_INV) begin
            // dividend starts as the raw operand, top bit taken as degree WORD_BITS-1
            y_in  = m_ff << align_sh;
            cx_in = CX_TOP;
            cy_in = signed'(DEG_W'(n_ff));
            sx_in = WORD_BITS'(1);
            sy_in = '0;
         end
      end

      case (cmd.op)
         DP_MRED: begin
            // Horner over the bits of a: reduces a mod m
            x_in   = x_ff << 1;
            cnt_in = cnt_ff + LOG_W'(1);
            h_in   = hx ^ WORD_BITS'(x_ff[WORD_BITS-1]);
            if (cnt_last) begin
               sy_in  = hx ^ WORD_BITS'(x_ff[WORD_BITS-1]);
               h_in   = '0;
               cnt_in = '0;
            end
         end
         DP_MPROD: begin
            y_in   = y_ff << 1;
            cnt_in = cnt_ff + LOG_W'(1);
            h_in   = hx ^ (y_ff[WORD_BITS-1] ? sy_ff : '0);
         end
         DP_DIV: begin
            // one quotient bit; h collects quotient * sy mod m
            x_in  = (x_ff[WORD_BITS-1] ? (x_ff ^ y_ff) : x_ff) << 1;
            cx_in = cx_ff - CX_ONE;
            h_in  = hx ^ (x_ff[WORD_BITS-1] ? sy_ff : '0);
         end
         DP_NORM: begin
            x_in  = x_ff << 1;
            cx_in = cx_ff - CX_ONE;
         end
         DP_SWAP: begin
            x_in  = y_ff;
            cx_in = cy_ff;
            y_in  = x_ff;
            cy_in = cx_ff;
            sx_in = sy_ff;
            sy_in = sx_ff ^ h_ff;
            h_in  = '0;
         end
         default: begin
            h_in = h_in;
         end
      endcase

      if (cmd.out_load) begin
         case (cmd.res_sel)
            RES_ZERO: begin
               result_in = '0;
               rstat_in  = STATUS_OK;
            end
            RES_BAD: begin
               result_in = '0;
               rstat_in  = STATUS_BAD_MODULUS;
            end
            RES_PROD: begin
               result_in = OPERAND_W'(h_ff);
               rstat_in  = STATUS_OK;
            end
            RES_INV: begin
               result_in = OPERAND_W'(sy_ff);
               rstat_in  = STATUS_OK;
            end
            default: begin
               result_in = '0;
               rstat_in  = STATUS_OK;
            end
         endcase
      end
   end

   assign product_or_inverse = result_ff;
   assign result_status      = rstat_ff;

endmodule

// ===== sim/gf2n_mul_inv_unit_test.sv =====
// Self-checking testbench of the GF(2^n) multiply / inverse unit.
`timescale 1ns / 1ps

module gf2n_mul_inv_unit_test;
   import gfmi_pkg::*;

   localparam int PHASES       = 13;
   localparam int PHASE_ITEMS  = 100;
   localparam int STALL_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 250;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [OPERAND_W-1:0] value;
      logic                 status;
   } field_result_type;

   typedef struct {
      logic                 is_write;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [MODULUS_W-1:0] reg_data;
      logic                 op;
      logic [OPERAND_W-1:0] a;
      logic [OPERAND_W-1:0] b;
      logic                 typed;
      logic [OPERAND_W-1:0] value;
      logic                 status;
   } stim_row_type;

   logic clock;
   logic reset;

   gfmi_req_if req_ch ();
   gfmi_rsp_if rsp_ch ();
   gfmi_csr_if csr_ch ();

   gf2n_mul_inv_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // field configuration as the block should hold it
   logic [CFG_DEG_W-1:0] cfg_degree;
   logic [MODULUS_W-1:0] cfg_modulus;

   field_result_type awaited_results[$];
   stim_row_type     stim_rows[$];

   // typed-in expectation of the request being driven
   logic                 row_typed;
   logic [OPERAND_W-1:0] row_value;
   logic                 row_status;

   logic steady;
   int   mismatch_count;
   int   idle_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int poly_deg(logic [63:0] p);
      int d;
      d = -1;
      for (int i = 0; i < 64; i++) if (p[i]) d = i;
      return d;
   endfunction

   function automatic logic [63:0] poly_mod(logic [63:0] p, logic [63:0] m, int n);
      int d;
      d = poly_deg(p);
      while (d >= n) begin
         p = p ^ (m << (d - n));
         d = poly_deg(p);
      end
      return p;
   endfunction

   function automatic logic [63:0] times_x_mod(logic [63:0] v, logic [63:0] m, int n);
      logic top;
      top = v[n-1];
      v = v << 1;
      if (top) v = v ^ m;
      return v;
   endfunction

   function automatic logic [63:0] field_mul(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] m, int n);
      logic [63:0] acc;
      acc = '0;
      while (b != 0) begin
         if (b[0]) acc = acc ^ a;
         a = times_x_mod(a, m, n);
         b = b >> 1;
      end
      return acc;
   endfunction

   // extended Euclid, Bezout coefficient of the operand kept reduced
   function automatic logic [63:0] field_inv(logic [63:0] a, logic [63:0] m, int n);
      logic [63:0] r0, r1, s0, s1, t, sh;
      int d0, d1;
      r0 = a;
      r1 = m;
      s0 = 64'd1;
      s1 = '0;
      while (r1 != 0) begin
         d0 = poly_deg(r0);
         d1 = poly_deg(r1);
         if (d0 < d1) begin
            t = r0; r0 = r1; r1 = t;
            t = s0; s0 = s1; s1 = t;
         end else begin
            r0 = r0 ^ (r1 << (d0 - d1));
            sh = s1;
            for (int k = 0; k < d0 - d1; k++) sh = times_x_mod(sh, m, n);
            s0 = s0 ^ sh;
         end
      end
      return s0;
   endfunction

   function automatic field_result_type compute_field_result(logic op,
                                                             logic [OPERAND_W-1:0] a_in,
                                                             logic [OPERAND_W-1:0] b_in);
      field_result_type r;
      int               n;
      logic [63:0]      a, b, p;
      n = (cfg_degree < MIN_DEGREE) ? int'(MIN_DEGREE) : int'(cfg_degree);
      a = {1'b0, a_in};
      b = {1'b0, b_in};
      p = '0;
      r.status = STATUS_OK;
      if (op == OP_MUL) begin
         // zero operands win over the modulus check
         if (a != 0 && b != 0) begin
            if (poly_deg(cfg_modulus) != n) begin
               r.status = STATUS_BAD_MODULUS;
            end else begin
               a = poly_mod(a, cfg_modulus, n);
               b = poly_mod(b, cfg_modulus, n);
               p = field_mul(a, b, cfg_modulus, n);
            end
         end
      end else begin
         if (a != 0) begin
            if (poly_deg(cfg_modulus) != n) begin
               r.status = STATUS_BAD_MODULUS;
            end else begin
               a = poly_mod(a, cfg_modulus, n);
               if (a != 0) p = field_inv(a, cfg_modulus, n);
            end
         end
      end
      r.value = p[OPERAND_W-1:0];
      return r;
   endfunction

   function automatic void add_op(logic op, logic [OPERAND_W-1:0] a, logic [OPERAND_W-1:0] b);
      stim_row_type row;
      row = '{1'b0, '0, '0, op, a, b, 1'b0, '0, STATUS_OK};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_op_fixed(logic op, logic [OPERAND_W-1:0] a,
                                        logic [OPERAND_W-1:0] b,
                                        logic [OPERAND_W-1:0] value, logic status);
      stim_row_type row;
      row = '{1'b0, '0, '0, op, a, b, 1'b1, value, status};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_write(logic [CSR_IDX_W-1:0] idx, logic [MODULUS_W-1:0] data);
      stim_row_type row;
      row = '{1'b1, idx, data, OP_MUL, '0, '0, 1'b0, '0, STATUS_OK};
      stim_rows.push_back(row);
   endfunction

   function automatic logic [OPERAND_W-1:0] rand_operand(int n);
      int          pick;
      logic [63:0] w;
      pick = $urandom_range(99);
      w = {$urandom, $urandom};
      if (pick < 6) return '0;
      if (pick < 14) return w[OPERAND_W-1:0];
      if (pick < 18) return 63'd1;
      return w[OPERAND_W-1:0] & ((63'd1 << n) - 63'd1);
   endfunction

   task automatic send_request(input logic op, input logic [OPERAND_W-1:0] a,
                               input logic [OPERAND_W-1:0] b, input logic typed,
                               input logic [OPERAND_W-1:0] value, input logic status);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 15) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      row_typed        <= typed;
      row_value        <= value;
      row_status       <= status;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MODULUS_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 15);
   end

   // response check, request and register tracking, stall watchdog
   always @(posedge clock) begin
      field_result_type want;
      logic             moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected response value %h status %0d", $realtime,
                           rsp_ch.product_or_inverse, rsp_ch.status);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ch.product_or_inverse !== want.value ||
                   rsp_ch.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: expected value %h status %0d, got value %h status %0d",
                              $realtime, want.value, want.status,
                              rsp_ch.product_or_inverse, rsp_ch.status);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            if (row_typed) begin
               want.value  = row_value;
               want.status = row_status;
            end else begin
               want = compute_field_result(req_ch.op, req_ch.operand_a, req_ch.operand_b);
            end
            awaited_results.push_back(want);
         end
         if (csr_ch.valid && csr_ch.ready) begin
            moved = 1'b1;
            if (csr_ch.index == CSR_FIELD_DEGREE) cfg_degree = csr_ch.data[CFG_DEG_W-1:0];
            else cfg_modulus = csr_ch.data;
         end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("gf2n_mul_inv_unit_test: done, errors");
         $finish;
      end
   end

   initial begin
      stim_row_type         row;
      int                   kind;
      int                   eff;
      int                   pick;
      logic [CFG_DEG_W-1:0] deg;
      logic [63:0]          w;
      logic [63:0]          modulus;

      reset            = 1'b1;
      steady           = 1'b0;
      mismatch_count   = 0;
      idle_cycles      = 0;
      cfg_degree       = FIELD_DEGREE_RESET;
      cfg_modulus      = MODULUS_RESET;
      row_typed        = 1'b0;
      row_value        = '0;
      row_status       = STATUS_OK;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_MUL;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_FIELD_DEGREE;
      csr_ch.data      = '0;

      // reset field: degree 8, AES modulus
      add_op_fixed(OP_MUL, 63'd0, 63'd5, 63'd0, STATUS_OK);
      add_op_fixed(OP_MUL, 63'd5, 63'd0, 63'd0, STATUS_OK);
      add_op_fixed(OP_INV, 63'd0, 63'd7, 63'd0, STATUS_OK);
      add_op_fixed(OP_MUL, 63'd1, 63'd1, 63'd1, STATUS_OK);
      add_op_fixed(OP_INV, 63'd1, 63'd0, 63'd1, STATUS_OK);
      add_op(OP_MUL, 63'h53, 63'hCA);
      add_op(OP_INV, 63'h53, 63'h0);
      add_op(OP_INV, 63'hFF, 63'h7FFF_FFFF_FFFF_FFFF);
      add_op(OP_MUL, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      add_op(OP_INV, 63'h7FFF_FFFF_FFFF_FFFF, 63'h0);
      // operand equal to the modulus reduces to zero
      add_op_fixed(OP_INV, 63'd283, 63'd0, 63'd0, STATUS_OK);
      add_op_fixed(OP_MUL, 63'd283, 63'd3, 63'd0, STATUS_OK);
      // degree 0 acts as 2, so the degree-8 modulus is flagged
      add_write(CSR_FIELD_DEGREE, 64'hFFFF_FFFF_FFFF_FFC0);
      add_op_fixed(OP_MUL, 63'd3, 63'd3, 63'd0, STATUS_BAD_MODULUS);
      add_op_fixed(OP_INV, 63'd3, 63'd0, 63'd0, STATUS_BAD_MODULUS);
      add_op_fixed(OP_INV, 63'd0, 63'd3, 63'd0, STATUS_OK);
      add_write(CSR_MODULUS_POLY, 64'd7);
      add_op(OP_MUL, 63'd2, 63'd2);
      add_op(OP_INV, 63'd2, 63'd0);
      // widest field, upper data bits of the degree write are dropped
      add_write(CSR_FIELD_DEGREE, 64'hFFFF_FFFF_FFFF_FFFF);
      add_write(CSR_MODULUS_POLY, 64'h8000_0000_0000_0003);
      add_op(OP_MUL, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      add_op(OP_INV, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      add_op(OP_MUL, 63'h4000_0000_0000_0000, 63'd2);
      add_write(CSR_MODULUS_POLY, 64'd0);
      add_op_fixed(OP_MUL, 63'd1, 63'd1, 63'd0, STATUS_BAD_MODULUS);
      // reducible modulus: inverse gives the Bezout coefficient, no flag
      add_write(CSR_MODULUS_POLY, 64'hFFFF_FFFF_FFFF_FFFF);
      add_op(OP_INV, 63'h5555_5555_5555_5555, 63'd0);
      add_op(OP_MUL, 63'h7FFF_FFFF_FFFF_FFFF, 63'h2AAA_AAAA_AAAA_AAAA);
      add_write(CSR_FIELD_DEGREE, 64'd1);
      add_write(CSR_MODULUS_POLY, 64'd7);
      add_op(OP_INV, 63'd3, 63'd0);
      add_write(CSR_FIELD_DEGREE, 64'd8);
      add_write(CSR_MODULUS_POLY, 64'd283);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.is_write) begin
            wait_drained();
            write_reg(row.reg_index, row.reg_data);
         end else begin
            send_request(row.op, row.a, row.b, row.typed, row.value, row.status);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         steady = (phase == 2 || phase == 3);
         kind = $urandom_range(9);
         w = {$urandom, $urandom};
         if (kind < 3) begin
            // irreducible moduli of a few sizes
            case ($urandom_range(6))
               0:       begin deg = 6'd2;  modulus = 64'h7;                   end
               1:       begin deg = 6'd3;  modulus = 64'hB;                   end
               2:       begin deg = 6'd4;  modulus = 64'h13;                  end
               3:       begin deg = 6'd8;  modulus = 64'h11B;                 end
               4:       begin deg = 6'd16; modulus = 64'h1002B;               end
               5:       begin deg = 6'd32; modulus = 64'h1_0000_008D;         end
               default: begin deg = 6'd63; modulus = 64'h8000_0000_0000_0003; end
            endcase
         end else begin
            case (kind)
               3:       deg = 6'd63;
               4:       deg = 6'd2;
               5:       deg = CFG_DEG_W'($urandom_range(1));
               default: deg = CFG_DEG_W'($urandom_range(62, 3));
            endcase
            eff = (deg < MIN_DEGREE) ? int'(MIN_DEGREE) : int'(deg);
            pick = $urandom_range(99);
            if (pick < 10) modulus = w;
            else if (pick < 16) modulus = w & ((64'd1 << eff) - 64'd1);
            else modulus = (64'd1 << eff) | (w & ((64'd1 << eff) - 64'd1)) | 64'd1;
         end
         w = {$urandom, $urandom};
         if ($urandom_range(1)) begin
            write_reg(CSR_FIELD_DEGREE, {w[63:CFG_DEG_W], deg});
            write_reg(CSR_MODULUS_POLY, modulus);
         end else begin
            write_reg(CSR_MODULUS_POLY, modulus);
            write_reg(CSR_FIELD_DEGREE, {w[63:CFG_DEG_W], deg});
         end
         eff = (deg < MIN_DEGREE) ? int'(MIN_DEGREE) : int'(deg);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // let the block run dry now and then
            if ((i == PHASE_ITEMS / 2 && phase % 4 == 1) || $urandom_range(63) == 0)
               wait_drained();
            send_request($urandom_range(1) ? OP_INV : OP_MUL, rand_operand(eff),
                         rand_operand(eff), 1'b0, '0, STATUS_OK);
         end
      end

      steady = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("gf2n_mul_inv_unit_test: done, clean");
      end else begin
         $display("gf2n_mul_inv_unit_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/gfmi_pkg.sv
rtl/core/gfmi_intf.sv
rtl/core/gfmi_ctrl.sv
rtl/core/gfmi_dpath.sv
rtl/core/gf2n_mul_inv_unit.sv
sim/gf2n_mul_inv_unit_test.sv
